[rtl/dcsc_pkg.sv]
// Shared types and constants for the DMA chain shadow checker.
package dcsc_pkg;

    localparam int CHAN_MAX_W = 4;
    localparam int SLOT_MAX_W = 8;
    localparam int SLOT_WORDS = 8;

    localparam logic [2:0] CFG_PROTECT_LOW  = 3'd0;
    localparam logic [2:0] CFG_PROTECT_HIGH = 3'd1;
    localparam logic [2:0] CFG_PHYS_MASK    = 3'd2;
    localparam logic [2:0] CFG_BUS_ALIAS    = 3'd3;
    localparam logic [2:0] CFG_SHADOW_BASE  = 3'd4;

    typedef enum logic [2:0] {
        ST_CONTINUE   = 3'd0,
        ST_CHAIN_DONE = 3'd1,
        ST_SRC_VIOL   = 3'd2,
        ST_DST_VIOL   = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_IGNORED    = 3'd5
    } t_status;

    // which shadow slot the rewritten next link points at
    typedef enum logic [1:0] {
        LK_NONE = 2'd0,
        LK_HEAD = 2'd1,
        LK_PREV = 2'd2,
        LK_NEXT = 2'd3
    } t_link;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_RUN  = 2'd1,
        BK_DONE = 2'd2
    } t_back_state;

    typedef struct packed {
        t_status                       status;
        t_link                         link;
        logic [CHAN_MAX_W-1:0]         chan;
        logic [SLOT_MAX_W-1:0]         slot;
        logic [31:0]                   fetch;
        logic [SLOT_WORDS-1:0][31:0]   words;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

[rtl/dcsc_front.sv]
// Front end: checks each request against the window and tracks chain state.
module dcsc_front #(
    parameter int CHANNELS    = 16,
    parameter int MAX_RECORDS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [31:0]         i_protect_low,
    input  logic [31:0]         i_protect_high,
    input  logic [31:0]         i_phys_mask,
    input  logic                i_first_record,
    input  logic [3:0]          i_channel,
    input  logic [31:0]         i_head_addr,
    input  logic [31:0]         i_transfer_info,
    input  logic [31:0]         i_src_addr,
    input  logic [31:0]         i_dst_addr,
    input  logic [31:0]         i_length,
    input  logic [31:0]         i_stride,
    input  logic [31:0]         i_next_addr,
    input  logic [31:0]         i_reserved_a,
    input  logic [31:0]         i_reserved_b,
    output dcsc_pkg::t_cmd      o_cmd
);
    import dcsc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_RECORDS);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_RECORDS - 1);
    localparam logic [4:0]        CHAN_LIM  = 5'(CHANNELS);

    logic [SLOT_W-1:0] r_count,   n_count;
    logic [31:0]       r_cur,     n_cur;
    logic [31:0]       r_prev,    n_prev;
    logic              r_prev_ok, n_prev_ok;
    logic [31:0]       r_head,    n_head;
    logic [CH_W-1:0]   r_chan,    n_chan;
    logic              r_aborted, n_aborted;

    logic        chan_ok;
    logic        ab_e;
    logic [31:0] src_pa, dst_pa, next_pa;
    logic        src_hit, dst_hit;
    t_status     status;
    t_link       link;

    always_comb begin
        chan_ok   = {1'b0, i_channel} < CHAN_LIM;
        n_count   = r_count;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_prev_ok = r_prev_ok;
        n_head    = r_head;
        n_chan    = r_chan;
        ab_e      = r_aborted;

        // a head record restarts the chain, unless its channel is out of range
        if (i_first_record) begin
            if (chan_ok) begin
                n_count   = '0;
                n_cur     = i_head_addr & i_phys_mask;
                n_prev    = '0;
                n_prev_ok = 1'b0;
                n_head    = i_head_addr;
                n_chan    = i_channel[CH_W-1:0];
                ab_e      = 1'b0;
            end else begin
                ab_e = 1'b1;
            end
        end

        src_pa  = i_src_addr & i_phys_mask;
        dst_pa  = i_dst_addr & i_phys_mask;
        next_pa = i_next_addr & i_phys_mask;
        src_hit = (src_pa >= i_protect_low) && (src_pa < i_protect_high);
        dst_hit = (dst_pa >= i_protect_low) && (dst_pa < i_protect_high);

        link = LK_NONE;
        if (ab_e) begin
            status = ST_IGNORED;
        end else if (src_hit) begin
            status = ST_SRC_VIOL;
        end else if (dst_hit) begin
            status = ST_DST_VIOL;
        end else if (i_next_addr == 32'd0) begin
            status = ST_CHAIN_DONE;
        end else if (i_next_addr == n_head) begin
            status = ST_CHAIN_DONE;
            link   = LK_HEAD;
        end else if (n_prev_ok && (n_count != '0) && (next_pa == n_prev)) begin
            status = ST_CHAIN_DONE;
            link   = LK_PREV;
        end else if (n_count == LAST_SLOT) begin
            status = ST_OVERFLOW;
        end else begin
            status = ST_CONTINUE;
            link   = LK_NEXT;
        end

        n_aborted = (status != ST_CONTINUE);

        o_cmd          = '0;
        o_cmd.status   = status;
        o_cmd.link     = link;
        o_cmd.chan     = CHAN_MAX_W'(n_chan);
        o_cmd.slot     = ab_e ? '0 : SLOT_MAX_W'(n_count);
        o_cmd.fetch    = (status == ST_CONTINUE) ? next_pa : 32'd0;
        o_cmd.words[0] = i_transfer_info;
        o_cmd.words[1] = i_src_addr;
        o_cmd.words[2] = i_dst_addr;
        o_cmd.words[3] = i_length;
        o_cmd.words[4] = i_stride;
        o_cmd.words[5] = i_next_addr;
        o_cmd.words[6] = i_reserved_a;
        o_cmd.words[7] = i_reserved_b;

        if (status == ST_CONTINUE) begin
            n_prev    = n_cur;
            n_prev_ok = 1'b1;
            n_cur     = next_pa;
            n_count   = n_count + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
            r_prev_ok <= 1'b0;
            r_head    <= '0;
            r_chan    <= '0;
            r_aborted <= 1'b1;
        end else if (i_accept) begin
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_prev    <= n_prev;
            r_prev_ok <= n_prev_ok;
            r_head    <= n_head;
            r_chan    <= n_chan;
            r_aborted <= n_aborted;
        end
    end

endmodule

[rtl/dcsc_queue.sv]
// Two-entry command queue between front and back.
module dcsc_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  dcsc_pkg::t_cmd           i_data,
    input  logic                     i_pop,
    output dcsc_pkg::t_cmd           o_data,
    output dcsc_pkg::t_queue_status  o_status
);
    import dcsc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
        o_data   = r_mem[r_rd_ptr];
        o_status.full  = (r_count == 2'd2);
        o_status.empty = (r_count == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/dcsc_back.sv]
// Back end: writes shadow slots word by word and forms the result.
module dcsc_back #(
    parameter int CHANNELS    = 16,
    parameter int MAX_RECORDS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [31:0]              i_bus_alias,
    input  logic [31:0]              i_shadow_base,
    input  dcsc_pkg::t_cmd           i_cmd,
    input  dcsc_pkg::t_queue_status  i_q,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_status,
    output logic [3:0]               o_slot_index,
    output logic [31:0]              o_shadow_next,
    output logic [31:0]              o_fetch_addr,
    output logic                     o_chain_done,
    output logic [31:0]              o_shadow_head
);
    import dcsc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_RECORDS);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LIN_N  = CHANNELS * MAX_RECORDS;
    localparam int LIN_W  = $clog2(LIN_N);
    localparam int DEPTH  = LIN_N * SLOT_WORDS;
    localparam int ADDR_W = LIN_W + 3;
    localparam logic [LIN_W-1:0] MAXR = LIN_W'(MAX_RECORDS);
    localparam logic [2:0]       NEXT_WORD = 3'd5;
    localparam logic [2:0]       LAST_WORD = 3'd7;

    logic [31:0] r_mem [DEPTH];

    t_back_state      r_state, n_state;
    logic [2:0]       r_step,  n_step;
    logic             r_out_valid, n_out_valid;
    t_cmd             r_cmd;
    logic [LIN_W-1:0] r_lin_base, r_lin;
    logic [31:0]      r_head_bus, r_snext;
    logic [2:0]       r_o_status;
    logic [3:0]       r_o_slot;
    logic [31:0]      r_o_snext, r_o_fetch, r_o_head;
    logic             r_o_done;

    logic             start, load_out, out_free;
    logic [LIN_W-1:0] pop_base, pop_lin, lin_sel;
    logic [31:0]      bus;
    logic             wen;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]      wdata;
    logic [SLOT_W+3:0] slot_ext;
    logic             ign;

    always_comb begin
        out_free = !r_out_valid || !i_stall;
        start    = 1'b0;
        load_out = 1'b0;
        n_state  = r_state;
        n_step   = r_step;
        case (r_state)
            BK_IDLE: begin
                start = !i_q.empty;
            end
            BK_RUN: begin
                if (r_step == LAST_WORD) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        start    = !i_q.empty;
                        n_state  = BK_IDLE;
                    end else begin
                        n_state = BK_DONE;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    start    = !i_q.empty;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (start) begin
            n_state = (i_cmd.status == ST_IGNORED) ? BK_DONE : BK_RUN;
            n_step  = 3'd0;
        end
        o_pop = start;

        pop_base = LIN_W'(i_cmd.chan[CH_W-1:0]) * MAXR;
        pop_lin  = pop_base + LIN_W'(i_cmd.slot[SLOT_W-1:0]);

        // one shared address adder: head slot first, then the link target
        if (r_step == 3'd0) begin
            lin_sel = r_lin_base;
        end else begin
            case (r_cmd.link)
                LK_HEAD: lin_sel = r_lin_base;
                LK_PREV: lin_sel = r_lin - LIN_W'(1);
                LK_NEXT: lin_sel = r_lin + LIN_W'(1);
                default: lin_sel = r_lin;
            endcase
        end
        bus = (i_shadow_base + 32'({lin_sel, 5'b0})) | i_bus_alias;

        case (r_cmd.status)
            ST_CONTINUE, ST_CHAIN_DONE: wen = 1'b1;
            ST_OVERFLOW:                wen = (r_step != NEXT_WORD);
            default:                    wen = 1'b0;
        endcase
        wen   = wen && (r_state == BK_RUN);
        waddr = {r_lin, r_step};
        wdata = (r_step == NEXT_WORD) ? r_snext : r_cmd.words[r_step];

        n_out_valid = load_out ? 1'b1 : (r_out_valid && i_stall);
        ign         = (r_cmd.status == ST_IGNORED);
        slot_ext    = {4'b0, r_cmd.slot[SLOT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd      <= i_cmd;
            r_lin_base <= pop_base;
            r_lin      <= pop_lin;
        end
        if (r_state == BK_RUN && r_step == 3'd0) begin
            r_head_bus <= bus;
        end
        if (r_state == BK_RUN && r_step == 3'd1) begin
            r_snext <= (r_cmd.link == LK_NONE) ? 32'd0 : bus;
        end
        if (load_out) begin
            r_o_status <= r_cmd.status;
            r_o_slot   <= ign ? 4'd0 : slot_ext[3:0];
            r_o_snext  <= ign ? 32'd0 : r_snext;
            r_o_fetch  <= r_cmd.fetch;
            r_o_done   <= (r_cmd.status != ST_CONTINUE);
            r_o_head   <= ign ? 32'd0 : r_head_bus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_slot_index  = r_o_slot;
    assign o_shadow_next = r_o_snext;
    assign o_fetch_addr  = r_o_fetch;
    assign o_chain_done  = r_o_done;
    assign o_shadow_head = r_o_head;

endmodule

[rtl/dma_chain_shadow_checker_top.sv]
// Top level of the DMA chain shadow checker: config registers and wiring.
//
//  channel   signals                          direction
//  --------  -------------------------------  ---------------------------
//  record    i_valid / o_stall + fields       in, one request per record
//  result    o_valid / i_stall + fields       out, one request per record
//  config    i_cfg_we, i_cfg_idx, i_cfg_data  in, write only
//
// A checked record steps through its shadow slot one word per cycle through
// the single store write port; continue and chain-done records write every
// word, an overflow all but the next link and a violation none. An ignored
// record skips the word steps.
// Reset clears control state only; the shadow store is not cleared.
// A two-entry queue takes records while results stall, until it is full.
module dma_chain_shadow_checker_top #(
    parameter int CHANNELS    = 16,
    parameter int MAX_RECORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_first_record,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_head_addr,
    input  logic [31:0] i_transfer_info,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_length,
    input  logic [31:0] i_stride,
    input  logic [31:0] i_next_addr,
    input  logic [31:0] i_reserved_a,
    input  logic [31:0] i_reserved_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [31:0] o_shadow_next,
    output logic [31:0] o_fetch_addr,
    output logic        o_chain_done,
    output logic [31:0] o_shadow_head
);
    import dcsc_pkg::*;

    logic [31:0] r_protect_low, r_protect_high, r_phys_mask, r_bus_alias, r_shadow_base;

    t_cmd          front_cmd, q_cmd;
    t_queue_status q_stat;
    logic          accept, pop;

    assign o_stall = q_stat.full;
    assign accept  = i_valid && !q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protect_low  <= 32'h0000_0000;
            r_protect_high <= 32'h0000_0000;
            r_phys_mask    <= 32'h3FFF_FFFF;
            r_bus_alias    <= 32'hC000_0000;
            r_shadow_base  <= 32'h0000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROTECT_LOW:  r_protect_low  <= i_cfg_data;
                CFG_PROTECT_HIGH: r_protect_high <= i_cfg_data;
                CFG_PHYS_MASK:    r_phys_mask    <= i_cfg_data;
                CFG_BUS_ALIAS:    r_bus_alias    <= i_cfg_data;
                CFG_SHADOW_BASE:  r_shadow_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dcsc_front #(
        .CHANNELS    (CHANNELS),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_protect_low   (r_protect_low),
        .i_protect_high  (r_protect_high),
        .i_phys_mask     (r_phys_mask),
        .i_first_record  (i_first_record),
        .i_channel       (i_channel),
        .i_head_addr     (i_head_addr),
        .i_transfer_info (i_transfer_info),
        .i_src_addr      (i_src_addr),
        .i_dst_addr      (i_dst_addr),
        .i_length        (i_length),
        .i_stride        (i_stride),
        .i_next_addr     (i_next_addr),
        .i_reserved_a    (i_reserved_a),
        .i_reserved_b    (i_reserved_b),
        .o_cmd           (front_cmd)
    );

    dcsc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_data   (front_cmd),
        .i_pop    (pop),
        .o_data   (q_cmd),
        .o_status (q_stat)
    );

    dcsc_back #(
        .CHANNELS    (CHANNELS),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bus_alias   (r_bus_alias),
        .i_shadow_base (r_shadow_base),
        .i_cmd         (q_cmd),
        .i_q           (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_shadow_next (o_shadow_next),
        .o_fetch_addr  (o_fetch_addr),
        .o_chain_done  (o_chain_done),
        .o_shadow_head (o_shadow_head)
    );

endmodule

[bench/dcsc_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the DMA chain shadow checker: predicts each result and compares it.
module dcsc_result_checker #(
    parameter int CHANNELS    = 16,
    parameter int MAX_RECORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_rec_valid,
    input  logic        i_rec_stall,
    input  logic        i_first_record,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_head_addr,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_next_addr,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [2:0]  i_status,
    input  logic [3:0]  i_slot_index,
    input  logic [31:0] i_shadow_next,
    input  logic [31:0] i_fetch_addr,
    input  logic        i_chain_done,
    input  logic [31:0] i_shadow_head,
    output int          o_mismatch_count,
    output int          o_pending_count
);
    import dcsc_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic [31:0] shadow_next;
        logic [31:0] fetch;
        logic        done;
        logic [31:0] head;
    } t_shadow_result;

    logic [31:0]    win_lo, win_hi, pa_mask, bus_or, base_pa;
    logic [31:0]    cur_rec_pa, prev_rec_pa, chain_head;
    logic [3:0]     chain_ch;
    logic           prev_seen, chain_dead;
    int             slots_used;
    t_shadow_result results_due[$];
    t_shadow_result seen, want;
    int             n_mismatch = 0;

    assign o_mismatch_count = n_mismatch;

    function automatic logic [31:0] slot_bus_addr(input logic [31:0] ch, input logic [31:0] slot);
        return (base_pa + ((ch * MAX_RECORDS + slot) << 5)) | bus_or;
    endfunction

    function automatic logic hits_window(input logic [31:0] pa);
        return pa >= win_lo && pa < win_hi;
    endfunction

    function automatic t_shadow_result predict_shadow_record(
        input logic first, input logic [3:0] ch,
        input logic [31:0] head, input logic [31:0] src,
        input logic [31:0] dst, input logic [31:0] link
    );
        t_shadow_result r;
        int             slot;
        r = '0;
        if (first) begin
            if (ch >= CHANNELS) begin
                chain_dead = 1'b1;
            end else begin
                chain_ch    = ch;
                chain_head  = head;
                cur_rec_pa  = head & pa_mask;
                prev_rec_pa = 32'h0;
                prev_seen   = 1'b0;
                slots_used  = 0;
                chain_dead  = 1'b0;
            end
        end
        if (chain_dead) begin
            r.status = ST_IGNORED;
            r.done   = 1'b1;
            return r;
        end
        slot   = slots_used;
        r.slot = slot[3:0];
        r.head = slot_bus_addr(chain_ch, 0);
        // source is checked before destination
        if (hits_window(src & pa_mask)) begin
            r.status = ST_SRC_VIOL;
        end else if (hits_window(dst & pa_mask)) begin
            r.status = ST_DST_VIOL;
        end else if (link == 32'h0) begin
            r.status = ST_CHAIN_DONE;
        end else if (link == chain_head) begin
            r.status      = ST_CHAIN_DONE;
            r.shadow_next = r.head;
        end else if (prev_seen && slot > 0 && (link & pa_mask) == prev_rec_pa) begin
            r.status      = ST_CHAIN_DONE;
            r.shadow_next = slot_bus_addr(chain_ch, slot - 1);
        end else if (slot + 1 >= MAX_RECORDS) begin
            r.status = ST_OVERFLOW;
        end else begin
            r.status      = ST_CONTINUE;
            r.shadow_next = slot_bus_addr(chain_ch, slot + 1);
            r.fetch       = link & pa_mask;
            prev_rec_pa   = cur_rec_pa;
            prev_seen     = 1'b1;
            cur_rec_pa    = r.fetch;
            slots_used    = slot + 1;
        end
        r.done = (r.status != ST_CONTINUE);
        if (r.done)
            chain_dead = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_lo      = 32'h0;
            win_hi      = 32'h0;
            pa_mask     = 32'h3FFF_FFFF;
            bus_or      = 32'hC000_0000;
            base_pa     = 32'h0;
            cur_rec_pa  = 32'h0;
            prev_rec_pa = 32'h0;
            chain_head  = 32'h0;
            chain_ch    = 4'h0;
            prev_seen   = 1'b0;
            chain_dead  = 1'b1;
            slots_used  = 0;
            results_due.delete();
            o_pending_count <= 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                seen.status      = t_status'(i_status);
                seen.slot        = i_slot_index;
                seen.shadow_next = i_shadow_next;
                seen.fetch       = i_fetch_addr;
                seen.done        = i_chain_done;
                seen.head        = i_shadow_head;
                if (results_due.size() == 0) begin
                    if (n_mismatch < 10)
                        $display("unexpected result: status %0d slot %0d next %h",
                                 i_status, i_slot_index, i_shadow_next);
                    n_mismatch++;
                end else begin
                    want = results_due.pop_front();
                    if (seen !== want) begin
                        if (n_mismatch < 10)
                            $display({"result mismatch: expected st %0d slot %0d next %h ",
                                      "fetch %h done %b head %h, got st %0d slot %0d ",
                                      "next %h fetch %h done %b head %h"},
                                     want.status, want.slot, want.shadow_next, want.fetch,
                                     want.done, want.head, i_status, i_slot_index,
                                     i_shadow_next, i_fetch_addr, i_chain_done,
                                     i_shadow_head);
                        n_mismatch++;
                    end
                end
            end
            if (i_rec_valid && !i_rec_stall)
                results_due.push_back(predict_shadow_record(i_first_record, i_channel,
                    i_head_addr, i_src_addr, i_dst_addr, i_next_addr));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROTECT_LOW:  win_lo  = i_cfg_data;
                    CFG_PROTECT_HIGH: win_hi  = i_cfg_data;
                    CFG_PHYS_MASK:    pa_mask = i_cfg_data;
                    CFG_BUS_ALIAS:    bus_or  = i_cfg_data;
                    CFG_SHADOW_BASE:  base_pa = i_cfg_data;
                    default: ;
                endcase
            end
            o_pending_count <= results_due.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the bench: clock, reset, record stimulus, result back-pressure and the verdict.
module testbench;
    import dcsc_pkg::*;

    localparam int         CHANNELS      = 16;
    localparam int         MAX_RECORDS   = 16;
    localparam logic [2:0] CFG_UNLISTED  = 3'd7;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         PHASE_RECORDS = 240;

    typedef enum logic [1:0] {
        END_ZERO = 2'd0,
        END_HEAD = 2'd1,
        END_PREV = 2'd2,
        END_OPEN = 2'd3
    } t_chain_end;

    typedef struct packed {
        logic        first;
        logic [3:0]  ch;
        logic [31:0] head, ti, src, dst, len, strd, nxt, ra, rb;
    } t_dma_record;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid, o_stall;
    logic        i_first_record;
    logic [3:0]  i_channel;
    logic [31:0] i_head_addr, i_transfer_info, i_src_addr, i_dst_addr;
    logic [31:0] i_length, i_stride, i_next_addr, i_reserved_a, i_reserved_b;
    logic        o_valid, i_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_slot_index;
    logic [31:0] o_shadow_next, o_fetch_addr, o_shadow_head;
    logic        o_chain_done;

    int          tx_idle_pct = 6;
    int          rx_idle_pct = 71;
    bit          hold_req    = 1'b0;
    logic [31:0] cfg_lo      = 32'h0;
    logic [31:0] cfg_hi      = 32'h0;
    logic [31:0] cfg_mask    = 32'h3FFF_FFFF;
    int          mismatch_total;
    int          results_owed;

    dma_chain_shadow_checker_top #(
        .CHANNELS    (CHANNELS),
        .MAX_RECORDS (MAX_RECORDS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_record  (i_first_record),
        .i_channel       (i_channel),
        .i_head_addr     (i_head_addr),
        .i_transfer_info (i_transfer_info),
        .i_src_addr      (i_src_addr),
        .i_dst_addr      (i_dst_addr),
        .i_length        (i_length),
        .i_stride        (i_stride),
        .i_next_addr     (i_next_addr),
        .i_reserved_a    (i_reserved_a),
        .i_reserved_b    (i_reserved_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_shadow_next   (o_shadow_next),
        .o_fetch_addr    (o_fetch_addr),
        .o_chain_done    (o_chain_done),
        .o_shadow_head   (o_shadow_head)
    );

    dcsc_result_checker #(
        .CHANNELS    (CHANNELS),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_result_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_rec_valid      (i_valid),
        .i_rec_stall      (o_stall),
        .i_first_record   (i_first_record),
        .i_channel        (i_channel),
        .i_head_addr      (i_head_addr),
        .i_src_addr       (i_src_addr),
        .i_dst_addr       (i_dst_addr),
        .i_next_addr      (i_next_addr),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_status         (o_status),
        .i_slot_index     (o_slot_index),
        .i_shadow_next    (o_shadow_next),
        .i_fetch_addr     (o_fetch_addr),
        .i_chain_done     (o_chain_done),
        .i_shadow_head    (o_shadow_head),
        .o_mismatch_count (mismatch_total),
        .o_pending_count  (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // result side: random stall, or one long hold-off on request from the main flow
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    function automatic bit lands_in_window(input logic [31:0] bus);
        return (bus & cfg_mask) >= cfg_lo && (bus & cfg_mask) < cfg_hi;
    endfunction

    // hit: aim inside the protected window; otherwise try to stay clear of it
    function automatic logic [31:0] pick_addr(input bit hit);
        logic [31:0] a;
        if (hit && cfg_hi > cfg_lo)
            return cfg_lo + ($urandom % (cfg_hi - cfg_lo));
        for (int t = 0; t < 16; t++) begin
            a = $urandom;
            if (!lands_in_window(a))
                return a;
        end
        if (!lands_in_window(32'hFFFF_FFFF))
            return 32'hFFFF_FFFF;
        return 32'h0;
    endfunction

    function automatic logic [31:0] fresh_link(input logic [31:0] head);
        logic [31:0] a;
        do a = $urandom; while (a == 32'h0 || a == head);
        return a;
    endfunction

    function automatic t_dma_record make_record(
        input logic first, input logic [3:0] ch, input logic [31:0] head,
        input logic [31:0] src, input logic [31:0] dst, input logic [31:0] nxt
    );
        t_dma_record r;
        r.first = first;
        r.ch    = ch;
        r.head  = head;
        r.ti    = $urandom;
        r.src   = src;
        r.dst   = dst;
        r.len   = $urandom;
        r.strd  = $urandom;
        r.nxt   = nxt;
        r.ra    = $urandom;
        r.rb    = $urandom;
        return r;
    endfunction

    // returns at the edge where the request is taken
    task automatic drive_record(input t_dma_record r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_first_record  <= r.first;
        i_channel       <= r.ch;
        i_head_addr     <= r.head;
        i_transfer_info <= r.ti;
        i_src_addr      <= r.src;
        i_dst_addr      <= r.dst;
        i_length        <= r.len;
        i_stride        <= r.strd;
        i_next_addr     <= r.nxt;
        i_reserved_a    <= r.ra;
        i_reserved_b    <= r.rb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    task automatic apply_settings(
        input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] mask,
        input logic [31:0] bus_or, input logic [31:0] base
    );
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PROTECT_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PROTECT_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PHYS_MASK;
        i_cfg_data <= mask;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BUS_ALIAS;
        i_cfg_data <= bus_or;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SHADOW_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        // unlisted index, must be dropped
        i_cfg_idx  <= CFG_UNLISTED;
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_lo   = lo;
        cfg_hi   = hi;
        cfg_mask = mask;
    endtask

    // mostly well-formed chains with random content, some noise and broken chains
    task automatic run_random_chains(input int quota);
        t_dma_record r;
        logic [31:0] head, nxt;
        logic [31:0] rec_addr [0:31];
        logic [3:0]  ch;
        t_chain_end  how;
        int          sent, len, k;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 8) begin
                r = make_record(1'($urandom_range(1)), 4'($urandom_range(15)), $urandom,
                                $urandom, $urandom, $urandom);
                drive_record(r);
                sent++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
                ch  = 4'($urandom_range(15));
                head = $urandom;
                how = t_chain_end'($urandom_range(3));
                rec_addr[0] = head;
                for (k = 0; k < len; k++) begin
                    if (k < len - 1 || how == END_OPEN) begin
                        nxt = fresh_link(head);
                    end else begin
                        case (how)
                            END_ZERO: nxt = 32'h0;
                            END_HEAD: nxt = head;
                            default:  nxt = (k > 0) ? rec_addr[k-1] ^ ($urandom & ~cfg_mask)
                                                    : 32'h0;
                        endcase
                    end
                    rec_addr[k+1] = nxt;
                    r = make_record(k == 0 || $urandom_range(49) == 0, ch, head,
                                    pick_addr($urandom_range(39) == 0),
                                    pick_addr($urandom_range(39) == 0), nxt);
                    drive_record(r);
                    sent++;
                end
                // stray record after the chain, usually ignored
                if ($urandom_range(3) == 0) begin
                    drive_record(make_record(1'b0, 4'($urandom_range(15)), $urandom,
                                             $urandom, $urandom, $urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int          phase, k;
        logic [31:0] rnd_lo;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_PROTECT_LOW;
        i_cfg_data      <= 32'h0;
        i_valid         <= 1'b0;
        i_first_record  <= 1'b0;
        i_channel       <= 4'h0;
        i_head_addr     <= 32'h0;
        i_transfer_info <= 32'h0;
        i_src_addr      <= 32'h0;
        i_dst_addr      <= 32'h0;
        i_length        <= 32'h0;
        i_stride        <= 32'h0;
        i_next_addr     <= 32'h0;
        i_reserved_a    <= 32'h0;
        i_reserved_b    <= 32'h0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty window
        drive_record(make_record(1'b0, 4'd3, $urandom, $urandom, $urandom, $urandom));
        drive_record(make_record(1'b1, 4'd0, 32'hC000_1000, 32'h0, 32'hFFFF_FFFF, 32'h0));
        drive_record(make_record(1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                 32'hC000_2000));
        drive_record(make_record(1'b0, 4'd7, $urandom, $urandom, $urandom, 32'hC000_3000));
        drive_record(make_record(1'b0, 4'd7, $urandom, $urandom, $urandom, 32'hFFFF_FFFF));
        drive_record(make_record(1'b1, 4'd5, 32'hC000_4000, $urandom, $urandom,
                                 32'hC000_5000));
        // same physical address as the head, other alias bits: link to previous
        drive_record(make_record(1'b0, 4'd5, $urandom, $urandom, $urandom, 32'h8000_4000));
        wait_drained();

        apply_settings(32'h1000_0000, 32'h2000_0000, 32'h3FFF_FFFF, 32'hC000_0000, 32'h0);
        drive_record(make_record(1'b1, 4'd1, $urandom, 32'hD000_0000, 32'h0, $urandom));
        drive_record(make_record(1'b0, 4'd1, $urandom, 32'h0, 32'h0, $urandom));
        drive_record(make_record(1'b1, 4'd2, $urandom, 32'h0, 32'h1FFF_FFFF, $urandom));
        drive_record(make_record(1'b1, 4'd2, $urandom, 32'h1000_0000, 32'h1000_0000,
                                 $urandom));
        // runs out of slots on the last one
        for (k = 0; k < MAX_RECORDS; k++)
            drive_record(make_record(k == 0, 4'd9, 32'hC0F0_0000, 32'h0, 32'h0,
                                     32'hC100_0000 + (k + 1) * 32'h100));

        for (phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: apply_settings(32'h1000_0000, 32'h2000_0000, 32'h3FFF_FFFF,
                                  32'hC000_0000, 32'h0010_0000);
                1: apply_settings(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_F000);
                2: apply_settings(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, $urandom);
                3: begin
                    rnd_lo = $urandom;
                    apply_settings(rnd_lo, rnd_lo + $urandom_range(32'h2000_0000), $urandom,
                                   $urandom, $urandom);
                end
                4: apply_settings(32'h0, 32'h0000_1000, 32'hFFFF_FFFF, 32'h4000_0000,
                                  32'h8000_0000);
                default: apply_settings(32'h3FFF_F000, 32'h4000_0000, 32'h3FFF_FFFF,
                                        32'hC000_0000, 32'hFFFF_FFE0);
            endcase
            if (phase < 2) begin
                tx_idle_pct = 6;
                rx_idle_pct = 71;
            end else if (phase < 4) begin
                tx_idle_pct = 71;
                rx_idle_pct = 6;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // results held back long enough to back the record side up
            if (phase == 4)
                hold_req = 1'b1;
            run_random_chains(PHASE_RECORDS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/dcsc_pkg.sv
rtl/dcsc_front.sv
rtl/dcsc_queue.sv
rtl/dcsc_back.sv
rtl/dma_chain_shadow_checker_top.sv
bench/dcsc_result_checker.sv
bench/testbench.sv
